// ===== rtl/slad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slad_pkg
// Shared types and constants of the supply loss alarm detector: payload
// layouts of the request and response streams, register indexes and reset
// values of the configuration registers.
// ----------------------------------------------------------------------------
package slad_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int SUM_W       = 16;
   localparam int RUN_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_SUM_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_RUN_NEEDED    = 2'd1;

   // Register reset values (threshold: 4.7 V average, 3.3 V ref, 1:3 divider)
   localparam logic [SUM_W-1:0] THRESHOLD_RESET = 16'd19446;
   localparam logic [RUN_W-1:0] RUN_NEEDED_RESET = 8'd10;
   localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

   // Request payload, lowest bits first: sample, on, off, pad
   typedef struct packed {
      logic [1:0]          pad;
      logic                off_request;
      logic                on_request;
      logic [SAMPLE_W-1:0] supply_sample;
   } req_data_type;

   // Response payload, lowest bits first: sum, present, alarm, started, stopped, pad
   typedef struct packed {
      logic [2:0]       pad;
      logic             alarm_stopped;
      logic             alarm_started;
      logic             alarm_on;
      logic             supply_present;
      logic [SUM_W-1:0] window_sum;
   } rsp_data_type;

   localparam int REQ_DATA_W = $bits(req_data_type);
   localparam int RSP_DATA_W = $bits(rsp_data_type);

endpackage

// ===== rtl/slad_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slad_ram
// Generic single-write, single-read synchronous RAM with registered read
// data.
// ----------------------------------------------------------------------------
module slad_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/supply_loss_alarm_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_loss_alarm_detector_top
// Moving-average undervoltage detector with a latched alarm.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one response per request: the
// read stage reads the oldest sample from the sample ring RAM, then the
// response step subtracts it from the running sum, adds the new sample,
// writes the new sample back into the same slot and updates the low-run
// counter, supply flag and alarm latch into the output register.
// A stalled response holds the pipeline; otherwise one transfer per cycle
// is sustained. Ring slots carry a valid bit that reset clears, so unwritten
// slots count as zero and no clearing pass is needed. Write the two
// configuration registers only while no request is in flight.
// ----------------------------------------------------------------------------
module supply_loss_alarm_detector_top #(
   parameter int WINDOW = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: supply_sample[11:0], on_request[12], off_request[13], zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [slad_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tdata: window_sum[15:0], supply_present[16], alarm_on[17],
   //        alarm_started[18], alarm_stopped[19], zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [slad_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [slad_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [slad_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import slad_pkg::*;

   localparam int PTR_W = $clog2(WINDOW);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW - 1);

   req_data_type req_data;
   logic         req_fire;
   logic         s1_adv;

   // Configuration registers
   logic [SUM_W-1:0] threshold_ff;
   logic [RUN_W-1:0] run_needed_ff;

   // Read stage
   logic [PTR_W-1:0] pos_ff, pos_in;
   logic             slot_valid_ff [WINDOW];
   logic             s1_valid_ff, s1_valid_in;
   req_data_type     s1_req_ff;
   logic [PTR_W-1:0] s1_pos_ff;
   logic             s1_old_valid_ff;

   // Detector state
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             present_ff, present_in;
   logic             alarm_ff, alarm_in;
   logic             started, stopped;

   // Ring RAM
   logic [SAMPLE_W-1:0] rd_data;
   logic [SAMPLE_W-1:0] old_sample;

   // Output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   assign req_data   = req_data_type'(req_tdata);
   assign s1_adv     = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_adv;
   assign req_fire   = req_tvalid & req_tready;

   slad_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_pos_ff),
      .wr_data (s1_req_ff.supply_sample),
      .rd_en   (req_fire),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   // Advance the ring position, wrapping at the window end
   always_comb begin
      pos_in = pos_ff;
      if (req_fire) begin
         pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
      end
      s1_valid_in = req_fire | (s1_valid_ff & ~s1_adv);
   end

   // Update sum, run counter, supply flag and alarm latch
   always_comb begin
      old_sample  = s1_old_valid_ff ? rd_data : '0;
      sum_in      = sum_ff - SUM_W'(old_sample) + SUM_W'(s1_req_ff.supply_sample);
      alarm_in    = alarm_ff | s1_req_ff.on_request;
      started     = 1'b0;
      stopped     = 1'b0;
      if (sum_in < threshold_ff) begin
         run_in = (run_ff == RUN_MAX) ? run_ff : run_ff + 1'b1;
      end else begin
         run_in = '0;
      end
      if (run_in >= run_needed_ff) begin
         if (present_ff) begin
            alarm_in = 1'b1;
            started  = 1'b1;
         end
         present_in = 1'b0;
      end else begin
         if (!present_ff) begin
            alarm_in = 1'b0;
            stopped  = 1'b1;
         end
         present_in = 1'b1;
      end
      if (s1_req_ff.off_request) begin
         alarm_in = 1'b0;
      end
      rsp_data_in.pad            = '0;
      rsp_data_in.alarm_stopped  = stopped;
      rsp_data_in.alarm_started  = started;
      rsp_data_in.alarm_on       = alarm_in;
      rsp_data_in.supply_present = present_in;
      rsp_data_in.window_sum     = sum_in;
      rsp_valid_in = s1_adv | (rsp_valid_ff & ~rsp_tready);
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         run_needed_ff <= RUN_NEEDED_RESET;
         pos_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         sum_ff        <= '0;
         run_ff        <= '0;
         present_ff    <= 1'b1;
         alarm_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_LOW_SUM_THRESHOLD: threshold_ff  <= csr_wdata[SUM_W-1:0];
               REG_LOW_RUN_NEEDED:    run_needed_ff <= csr_wdata[RUN_W-1:0];
               default: ;
            endcase
         end
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            sum_ff                   <= sum_in;
            run_ff                   <= run_in;
            present_ff               <= present_in;
            alarm_ff                 <= alarm_in;
            slot_valid_ff[s1_pos_ff] <= 1'b1;
         end
      end
   end

   // Payload registers of the read stage and the response
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff       <= req_data;
         s1_pos_ff       <= pos_ff;
         s1_old_valid_ff <= slot_valid_ff[pos_ff];
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/slad_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slad_checker
// Port-level checks of the supply loss alarm detector, bound to the top level.
// ----------------------------------------------------------------------------
module slad_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [slad_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import slad_pkg::*;

   rsp_data_type rsp;
   assign rsp = rsp_data_type'(rsp_tdata);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Loss detection leaves the supply marked lost
   a_started_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.alarm_started |-> !rsp.supply_present)
      else $error("alarm started with supply present");

   // Supply return marks present and clears the alarm
   a_stopped_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.alarm_stopped |-> rsp.supply_present && !rsp.alarm_on)
      else $error("alarm stopped without supply return");

   // No response right after reset
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind supply_loss_alarm_detector_top slad_checker u_slad_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
